### rtl/quaternion_point_rotation_macros.svh
// Assertion macros for the quaternion point rotation block.
`ifndef QUATERNION_POINT_ROTATION_MACROS_SVH
`define QUATERNION_POINT_ROTATION_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define QPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define QPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/qpr_pkg.sv
// Types and constants for the quaternion point rotation block.
`default_nettype none

package qpr_pkg;

    localparam int CW   = 32;   // component width
    localparam int MW   = 66;   // rotation matrix entry, norm
    localparam int HALF = 33;   // split point of a matrix entry for the multipliers
    localparam int PW   = 98;   // matrix entry times point component
    localparam int SW   = 100;  // sums, dividend, remainder
    localparam int QB   = 32;   // quotient bits
    localparam int IDXW = 4;    // config index width

    localparam logic [IDXW-1:0] REG_ROTOR_W = 4'd0;
    localparam logic [IDXW-1:0] REG_ROTOR_X = 4'd1;
    localparam logic [IDXW-1:0] REG_ROTOR_Y = 4'd2;
    localparam logic [IDXW-1:0] REG_ROTOR_Z = 4'd3;

    localparam logic signed [CW-1:0] ROTOR_W_RESET = 32'sh4000_0000;
    localparam logic signed [CW-1:0] SAT_POS = 32'sh7FFF_FFFF;
    localparam logic signed [CW-1:0] SAT_NEG = 32'sh8000_0000;

    typedef struct packed {
        logic signed [CW-1:0] point_w;
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [CW-1:0] out_w;
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic                 zero_rotor;
        logic                 saturated;
    } result_t;

endpackage

`default_nettype wire

### rtl/quaternion_point_rotation.sv
// Quaternion point rotation r*p*conj(r)/|r|^2, pipelined, one item per cycle while not stalled.
//
//   channel  signals                                  direction
//   point    point_valid, point_ready, point          in
//   result   result_valid, result_ready, result       out
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data in
//
// One item per cycle sustained while result_ready stays high and no cfg write is made.
// The quotient comes from the 32-stage restoring quotient chain (one bit per stage).
// point_ready stays low after reset and after each cfg write while the
// rotation matrix and norm are rebuilt from the rotor registers.
// The pipe advances unless the 2-entry output buffer is full; result_ready has no
// combinational path to point_ready.
`default_nettype none

`include "quaternion_point_rotation_macros.svh"

module quaternion_point_rotation (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       point_valid,
    output logic                       point_ready,
    input  qpr_pkg::point_t            point,
    output logic                       result_valid,
    input  logic                       result_ready,
    output qpr_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [qpr_pkg::IDXW-1:0]   cfg_index,
    input  logic [qpr_pkg::CW-1:0]     cfg_data
);
    import qpr_pkg::*;

    localparam int DIV0 = 7;            // stage holding the quotient chain entry
    localparam int NST  = DIV0 + QB + 1;
    localparam logic [1:0] SETTLE = 2'd3;
    localparam logic [1:0] BUF_FULL = 2'd2;

    // rotor registers and derived matrix
    logic signed [CW-1:0]   rotor_w_reg, rotor_x_reg, rotor_y_reg, rotor_z_reg;
    logic signed [2*CW-1:0] ww_reg, xx_reg, yy_reg, zz_reg, xy_reg;
    logic signed [2*CW-1:0] xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [MW-1:0]   nm_reg [3][3];
    logic [MW-1:0]          n_reg;
    logic [MW-1:0]          d;
    logic                   zero_n;
    logic [1:0]             settle_reg;

    // pipeline
    logic                   en;
    logic [NST-1:0]         v_reg;
    logic signed [CW-1:0]   pw_reg [NST];
    point_t                 p_reg;
    logic signed [CW-1:0]   pc [3];
    logic signed [MW-1:0]   lo_reg [3][3];
    logic signed [MW-2:0]   hi_reg [3][3];
    logic signed [PW-1:0]   prod_reg [3][3];
    logic signed [SW-1:0]   part_reg [3];
    logic signed [PW-1:0]   t2_reg [3];
    logic signed [SW-1:0]   s_reg [3];
    logic signed [SW-1:0]   a_reg [3];
    logic [SW-1:0]          m_reg [3];
    logic                   neg6_reg [3];
    logic [SW-1:0]          rem_reg [QB+1][3];
    logic [QB-1:0]          q_reg [QB+1][3];
    logic                   neg_reg [QB+1][3];
    logic                   ovf_reg [QB+1][3];

    // finish and output buffer
    logic signed [CW-1:0]   fin_val [3];
    logic                   fin_sat [3];
    result_t                fin_result;
    result_t                out_reg, skid_reg;
    logic [1:0]             cnt_reg, cnt_next;
    logic                   push, pop;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotor_w_reg <= ROTOR_W_RESET;
            rotor_x_reg <= '0;
            rotor_y_reg <= '0;
            rotor_z_reg <= '0;
            settle_reg  <= SETTLE;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                settle_reg <= SETTLE;
                case (cfg_index)
                    REG_ROTOR_W: rotor_w_reg <= cfg_data;
                    REG_ROTOR_X: rotor_x_reg <= cfg_data;
                    REG_ROTOR_Y: rotor_y_reg <= cfg_data;
                    REG_ROTOR_Z: rotor_z_reg <= cfg_data;
                    default:     ;
                endcase
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    // pairwise products, then the unnormalized rotation matrix and |r|^2
    always_ff @(posedge clk)
    begin
        ww_reg <= rotor_w_reg * rotor_w_reg;
        xx_reg <= rotor_x_reg * rotor_x_reg;
        yy_reg <= rotor_y_reg * rotor_y_reg;
        zz_reg <= rotor_z_reg * rotor_z_reg;
        xy_reg <= rotor_x_reg * rotor_y_reg;
        xz_reg <= rotor_x_reg * rotor_z_reg;
        yz_reg <= rotor_y_reg * rotor_z_reg;
        wx_reg <= rotor_w_reg * rotor_x_reg;
        wy_reg <= rotor_w_reg * rotor_y_reg;
        wz_reg <= rotor_w_reg * rotor_z_reg;

        nm_reg[0][0] <= MW'(ww_reg) + MW'(xx_reg) - MW'(yy_reg) - MW'(zz_reg);
        nm_reg[0][1] <= (MW'(xy_reg) - MW'(wz_reg)) <<< 1;
        nm_reg[0][2] <= (MW'(xz_reg) + MW'(wy_reg)) <<< 1;
        nm_reg[1][0] <= (MW'(xy_reg) + MW'(wz_reg)) <<< 1;
        nm_reg[1][1] <= MW'(ww_reg) - MW'(xx_reg) + MW'(yy_reg) - MW'(zz_reg);
        nm_reg[1][2] <= (MW'(yz_reg) - MW'(wx_reg)) <<< 1;
        nm_reg[2][0] <= (MW'(xz_reg) - MW'(wy_reg)) <<< 1;
        nm_reg[2][1] <= (MW'(yz_reg) + MW'(wx_reg)) <<< 1;
        nm_reg[2][2] <= MW'(ww_reg) - MW'(xx_reg) - MW'(yy_reg) + MW'(zz_reg);
        n_reg        <= MW'(ww_reg) + MW'(xx_reg) + MW'(yy_reg) + MW'(zz_reg);
    end

    assign d      = n_reg << 1;
    assign zero_n = (n_reg == '0);

    // ---------------------------------------------------------------- pipeline
    assign en          = (cnt_reg != BUF_FULL);
    assign point_ready = en && (settle_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], point_valid && point_ready};
        end
    end

    assign pc[0] = p_reg.point_x;
    assign pc[1] = p_reg.point_y;
    assign pc[2] = p_reg.point_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= point;
            pw_reg[0] <= point.point_w;
            for (int k = 1; k < NST; k++)
            begin
                pw_reg[k] <= pw_reg[k-1];
            end

            // matrix entry split in two halves so each multiplier stays near 32x32
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lo_reg[i][j] <= MW'($signed({1'b0, nm_reg[i][j][HALF-1:0]}))
                                    * MW'(pc[j]);
                    hi_reg[i][j] <= (MW-1)'($signed(nm_reg[i][j][MW-1:HALF]))
                                    * (MW-1)'(pc[j]);
                    prod_reg[i][j] <= (PW'(hi_reg[i][j]) <<< HALF) + PW'(lo_reg[i][j]);
                end
            end

            for (int i = 0; i < 3; i++)
            begin
                part_reg[i] <= SW'(prod_reg[i][0]) + SW'(prod_reg[i][1]);
                t2_reg[i]   <= prod_reg[i][2];
                s_reg[i]    <= part_reg[i] + SW'(t2_reg[i]);
                // round half up: floor((2s + n) / 2n)
                a_reg[i]    <= (s_reg[i] <<< 1) + $signed(SW'(n_reg));
                neg6_reg[i] <= a_reg[i][SW-1];
                // floor for negative dividend: magnitude is d - 1 - a
                m_reg[i]    <= a_reg[i][SW-1] ? SW'(d) + ~a_reg[i] : a_reg[i];

                rem_reg[0][i] <= m_reg[i];
                q_reg[0][i]   <= '0;
                neg_reg[0][i] <= neg6_reg[i];
                ovf_reg[0][i] <= (m_reg[i] >= (SW'(d) << QB));
            end

            for (int j = 1; j <= QB; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[j][i] <= neg_reg[j-1][i];
                    ovf_reg[j][i] <= ovf_reg[j-1][i];
                    if (rem_reg[j-1][i] >= (SW'(d) << (QB - j)))
                    begin
                        rem_reg[j][i] <= rem_reg[j-1][i] - (SW'(d) << (QB - j));
                        q_reg[j][i]   <= q_reg[j-1][i] | (QB'(1) << (QB - j));
                    end
                    else
                    begin
                        rem_reg[j][i] <= rem_reg[j-1][i];
                        q_reg[j][i]   <= q_reg[j-1][i];
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- finish
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (neg_reg[QB][i])
            begin
                fin_sat[i] = ovf_reg[QB][i] || (q_reg[QB][i] > QB'(SAT_NEG));
                fin_val[i] = fin_sat[i] ? SAT_NEG : $signed(-q_reg[QB][i]);
            end
            else
            begin
                fin_sat[i] = ovf_reg[QB][i] || q_reg[QB][i][QB-1];
                fin_val[i] = fin_sat[i] ? SAT_POS : $signed(q_reg[QB][i]);
            end
        end

        if (zero_n)
        begin
            fin_result            = '0;
            fin_result.zero_rotor = 1'b1;
        end
        else
        begin
            fin_result.out_w      = pw_reg[NST-1];
            fin_result.out_x      = fin_val[0];
            fin_result.out_y      = fin_val[1];
            fin_result.out_z      = fin_val[2];
            fin_result.zero_rotor = 1'b0;
            fin_result.saturated  = fin_sat[0] || fin_sat[1] || fin_sat[2];
        end
    end

    // ---------------------------------------------------------------- output buffer
    assign push = en && v_reg[NST-1];
    assign pop  = result_valid && result_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (cnt_reg == BUF_FULL))
        begin
            out_reg <= skid_reg;
        end
        else if (push && ((cnt_reg == '0) || pop))
        begin
            out_reg <= fin_result;
        end

        if (push && !pop && (cnt_reg != '0))
        begin
            skid_reg <= fin_result;
        end
    end

    assign result_valid = (cnt_reg != '0);
    assign result       = out_reg;

    // ---------------------------------------------------------------- checks
    `QPR_ASSERT_NOW(a_full_blocks_input, cnt_reg == BUF_FULL, !point_ready,
        "input accepted while output buffer full")
    `QPR_ASSERT_NOW(a_zero_rotor_clean, result_valid && result.zero_rotor,
        !result.saturated && (result.out_w == '0) && (result.out_x == '0),
        "zero rotor result carries nonzero fields")
    `QPR_ASSERT_NEXT(a_cfg_settles, cfg_valid && cfg_ready, !point_ready,
        "input accepted before matrix rebuilt after cfg write")

endmodule

`default_nettype wire
